// ===== hw/rtl/rmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rmc_pkg: shared types and constants for the random maze carver
// Payload structs, register indexes and the direction permutation table.
// ----------------------------------------------------------------------------
package rmc_pkg;

  localparam int MaxDim        = 64;
  localparam int DimW          = $clog2(MaxDim);
  localparam int MapDepth      = MaxDim * MaxDim;
  localparam int MapAw         = 2 * DimW;
  localparam int FrontierDepth = 1024;
  localparam int FrontAw       = $clog2(FrontierDepth);
  localparam int CountW        = FrontAw + 1;
  localparam int RandW         = 15;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 6;

  // Shared subtractor: the frontier count shifted up by RandW-1 must fit.
  localparam int SubW          = CountW + RandW - 1;
  // Number of direction orders, and the largest shift of it below 2^RandW.
  localparam int OrdMod        = 24;
  localparam int OrdShift      = 10;

  localparam logic [CfgIdxW-1:0] RegGridRows = 1'b0;
  localparam logic [CfgIdxW-1:0] RegGridCols = 1'b1;

  localparam logic ActStart = 1'b0;
  localparam logic ActStep  = 1'b1;

  typedef struct packed {
    logic             action;
    logic [RandW-1:0] pick_random;
    logic [RandW-1:0] order_random;
  } rmc_req_t;

  typedef struct packed {
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic [5:0] wall_row;
    logic [5:0] wall_col;
    logic       wall_opened;
    logic       step_done;
    logic       maze_finished;
  } rmc_rsp_t;

  // Entry i of a permutation, packed two bits per direction, first at the top.
  function automatic logic [1:0] perm_dir(input logic [4:0] sel, input logic [1:0] i);
    logic [7:0] p;
    case (sel)
      5'd0:  p = {2'd0, 2'd1, 2'd2, 2'd3};
      5'd1:  p = {2'd0, 2'd1, 2'd3, 2'd2};
      5'd2:  p = {2'd0, 2'd2, 2'd1, 2'd3};
      5'd3:  p = {2'd0, 2'd2, 2'd3, 2'd1};
      5'd4:  p = {2'd0, 2'd3, 2'd2, 2'd1};
      5'd5:  p = {2'd0, 2'd3, 2'd1, 2'd2};
      5'd6:  p = {2'd1, 2'd0, 2'd2, 2'd3};
      5'd7:  p = {2'd1, 2'd0, 2'd3, 2'd2};
      5'd8:  p = {2'd1, 2'd2, 2'd3, 2'd0};
      5'd9:  p = {2'd1, 2'd2, 2'd0, 2'd3};
      5'd10: p = {2'd1, 2'd3, 2'd0, 2'd2};
      5'd11: p = {2'd1, 2'd3, 2'd2, 2'd0};
      5'd12: p = {2'd2, 2'd0, 2'd1, 2'd3};
      5'd13: p = {2'd2, 2'd0, 2'd3, 2'd1};
      5'd14: p = {2'd2, 2'd1, 2'd3, 2'd0};
      5'd15: p = {2'd2, 2'd1, 2'd0, 2'd3};
      5'd16: p = {2'd2, 2'd3, 2'd1, 2'd0};
      5'd17: p = {2'd2, 2'd3, 2'd0, 2'd1};
      5'd18: p = {2'd3, 2'd0, 2'd1, 2'd2};
      5'd19: p = {2'd3, 2'd0, 2'd2, 2'd1};
      5'd20: p = {2'd3, 2'd1, 2'd2, 2'd0};
      5'd21: p = {2'd3, 2'd1, 2'd0, 2'd2};
      5'd22: p = {2'd3, 2'd2, 2'd1, 2'd0};
      5'd23: p = {2'd3, 2'd2, 2'd0, 2'd1};
      default: p = 8'd0;
    endcase
    return p[(3 - i) * 2 +: 2];
  endfunction

endpackage

// ===== hw/rtl/random_maze_carver.sv =====
// ----------------------------------------------------------------------------
// random_maze_carver: randomized Prim maze carving, one frontier cell a request
// A sequencer drives one shared subtract/compare unit and single-port maps.
// ----------------------------------------------------------------------------
//  channel | direction | handshake     | payload
//  req     | in        | valid / stall | rmc_req_t
//  rsp     | out       | valid / stall | rmc_rsp_t
//  cfg     | in        | valid / ready | index, data
//
// A start request sweeps the 4096-entry map clear, one entry a cycle, then
// seeds cell (1,1) and offers its response. After reset the same clearing
// pass runs once before the first request is taken. A step response follows
// the pick reduction, the order reduction, the neighbour tests and the
// appends, plus the order-preserving removal, which moves each frontier
// entry behind the picked one. A step on an empty frontier is answered in
// the next cycle.
// A stalled response holds; no request is taken until it is delivered.
module random_maze_carver
  import rmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  rmc_req_t            req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output rmc_rsp_t            rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    StClear, StSeed, StIdle, StModPick, StModSwap, StModOrd, StRdCur, StCurWait,
    StShiftRd, StShiftWr, StMarkCur, StNbRd, StNbWait, StNbCheck, StWallWr,
    StCarve, StQRd, StQWait, StQCheck, StQWr, StResp
  } state_e;

  state_e state_q;

  // Map memories: bit 0 open, bit 1 carved, bit 2 queued.
  logic [2:0]          map_mem [MapDepth];
  logic [2:0]          map_rd_q;
  logic [MapAw-1:0]    map_addr;
  logic                map_we;
  logic [2:0]          map_wd;

  logic [2*DimW-1:0]   front_mem [FrontierDepth];
  logic [2*DimW-1:0]   front_rd_q;
  logic [FrontAw-1:0]  front_addr;
  logic                front_we;
  logic [2*DimW-1:0]   front_wd;

  logic [5:0]          rows_q, cols_q;
  logic [CountW-1:0]   count_q;
  logic [MapAw-1:0]    clr_q;
  logic [RandW-1:0]    rem_q;
  logic [SubW-1:0]     sub_q;      // shifted divisor of the shared subtractor
  logic [3:0]          sh_q;
  logic [4:0]          ord_q;
  logic [RandW-1:0]    ord_raw_q;
  logic [FrontAw-1:0]  pos_q;
  logic [5:0]          cur_r_q, cur_c_q;
  logic [1:0]          i_q;
  rmc_rsp_t            rsp_q;

  // Neighbour of the current cell in direction dir, or the cell itself.
  logic [1:0] nb_dir;
  logic [5:0] nb_r, nb_c;
  logic [6:0] tr, tc;
  assign nb_dir = (state_q == StNbRd || state_q == StNbWait || state_q == StNbCheck ||
                   state_q == StWallWr) ? perm_dir(ord_q, i_q) : i_q;
  always_comb begin
    tr = {1'b0, cur_r_q};
    tc = {1'b0, cur_c_q};
    case (nb_dir)
      2'd0:    tr = {1'b0, cur_r_q} - 7'd2;
      2'd1:    tr = {1'b0, cur_r_q} + 7'd2;
      2'd2:    tc = {1'b0, cur_c_q} - 7'd2;
      default: tc = {1'b0, cur_c_q} + 7'd2;
    endcase
    if (!tr[6] && tr != 7'd0 && tr < {1'b0, rows_q} &&
        !tc[6] && tc != 7'd0 && tc < {1'b0, cols_q}) begin
      nb_r = tr[5:0];
      nb_c = tc[5:0];
    end else begin
      nb_r = cur_r_q;
      nb_c = cur_c_q;
    end
  end

  logic [5:0] wall_r, wall_c;
  logic [6:0] sum_r, sum_c;
  assign sum_r  = {1'b0, nb_r} + {1'b0, cur_r_q};
  assign sum_c  = {1'b0, nb_c} + {1'b0, cur_c_q};
  assign wall_r = sum_r[6:1];
  assign wall_c = sum_c[6:1];

  // Shared subtract/compare unit used for both modulo reductions.
  logic [SubW-1:0] rem_ext;
  logic            sub_ok;
  assign rem_ext = {{(SubW-RandW){1'b0}}, rem_q};
  assign sub_ok  = rem_ext >= sub_q;

  always_comb begin
    map_we     = 1'b0;
    map_wd     = 3'b000;
    map_addr   = {nb_r, nb_c};
    front_we   = 1'b0;
    front_wd   = {nb_r, nb_c};
    front_addr = pos_q;
    unique case (state_q)
      StClear: begin
        map_we   = 1'b1;
        map_addr = clr_q;
        map_wd   = 3'b000;
      end
      StSeed: begin
        // Cell (1,1) is open and is the only frontier entry.
        map_we     = 1'b1;
        map_addr   = {6'd1, 6'd1};
        map_wd     = 3'b101;
        front_we   = 1'b1;
        front_addr = '0;
        front_wd   = {6'd1, 6'd1};
      end
      StRdCur:   front_addr = pos_q;
      StShiftRd: front_addr = pos_q + FrontAw'(1);
      StShiftWr: begin
        front_we = 1'b1;
        front_wd = front_rd_q;
      end
      StMarkCur: begin
        // A frontier cell is never carved yet: open it and drop its queued mark.
        map_we   = 1'b1;
        map_addr = {cur_r_q, cur_c_q};
        map_wd   = 3'b001;
      end
      StWallWr: begin
        // Walls sit between cells and only ever carry the open mark.
        map_we   = 1'b1;
        map_addr = {wall_r, wall_c};
        map_wd   = 3'b001;
      end
      StCarve: begin
        map_we   = 1'b1;
        map_addr = {cur_r_q, cur_c_q};
        map_wd   = 3'b011;
      end
      StQWr: begin
        map_we     = 1'b1;
        map_wd     = map_rd_q | 3'b100;
        front_we   = 1'b1;
        front_addr = count_q[FrontAw-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_addr] <= map_wd;
    map_rd_q <= map_mem[map_addr];
    if (front_we) front_mem[front_addr] <= front_wd;
    front_rd_q <= front_mem[front_addr];
  end

  assign req_stall_o = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = (state_q == StResp);
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      count_q   <= '0;
      rows_q    <= 6'd33;
      cols_q    <= 6'd41;
      rem_q     <= '0;
      sub_q     <= '0;
      sh_q      <= '0;
      ord_q     <= '0;
      ord_raw_q <= '0;
      pos_q     <= '0;
      cur_r_q   <= '0;
      cur_c_q   <= '0;
      i_q       <= '0;
      rsp_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegGridRows) rows_q <= cfg_data_i;
        if (cfg_index_i == RegGridCols) cols_q <= cfg_data_i;
      end
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + MapAw'(1);
          if (clr_q == MapAw'(MapDepth - 1)) begin
            // A start request leaves the count at one; the reset pass at zero.
            if (count_q == CountW'(1)) begin
              state_q <= StSeed;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        StSeed: state_q <= StResp;
        StIdle: begin
          if (req_valid_i) begin
            rem_q     <= req_i.pick_random;
            ord_raw_q <= req_i.order_random;
            if (req_i.action == ActStart) begin
              count_q <= CountW'(1);
              clr_q   <= '0;
              state_q <= StClear;
            end else if (count_q == '0 || count_q > CountW'(FrontierDepth)) begin
              count_q             <= '0;
              rsp_q.maze_finished <= 1'b1;
              state_q             <= StResp;
            end else begin
              sub_q   <= {count_q, {(RandW-1){1'b0}}};
              sh_q    <= '0;
              state_q <= StModPick;
            end
          end
        end
        StModPick: begin
          // Restoring reduction, one shifted divisor a cycle.
          if (sub_ok) rem_q <= rem_q - sub_q[RandW-1:0];
          sub_q <= sub_q >> 1;
          sh_q  <= sh_q + 4'd1;
          if (sh_q == 4'(RandW - 1)) state_q <= StModSwap;
        end
        StModSwap: begin
          pos_q   <= rem_q[FrontAw-1:0];
          rem_q   <= ord_raw_q;
          sub_q   <= SubW'(OrdMod) << OrdShift;
          sh_q    <= '0;
          state_q <= StModOrd;
        end
        StModOrd: begin
          if (sub_ok) rem_q <= rem_q - sub_q[RandW-1:0];
          sub_q <= sub_q >> 1;
          sh_q  <= sh_q + 4'd1;
          if (sh_q == 4'(OrdShift)) state_q <= StRdCur;
        end
        StRdCur: begin
          ord_q   <= rem_q[4:0];
          state_q <= StCurWait;
        end
        StCurWait: begin
          cur_r_q <= front_rd_q[2*DimW-1:DimW];
          cur_c_q <= front_rd_q[DimW-1:0];
          state_q <= StShiftRd;
        end
        StShiftRd: begin
          if ({1'b0, pos_q} + CountW'(1) >= count_q) begin
            count_q <= count_q - CountW'(1);
            state_q <= StMarkCur;
          end else begin
            state_q <= StShiftWr;
          end
        end
        StShiftWr: begin
          pos_q   <= pos_q + FrontAw'(1);
          state_q <= StShiftRd;
        end
        StMarkCur: begin
          state_q        <= StNbRd;
          i_q            <= 2'd0;
          rsp_q.cell_row <= cur_r_q;
          rsp_q.cell_col <= cur_c_q;
        end
        StNbRd:   state_q <= StNbWait;
        StNbWait: state_q <= StNbCheck;
        StNbCheck: begin
          if (map_rd_q[1] && !(nb_r == cur_r_q && nb_c == cur_c_q)) begin
            rsp_q.wall_row    <= wall_r;
            rsp_q.wall_col    <= wall_c;
            rsp_q.wall_opened <= 1'b1;
            state_q           <= StWallWr;
          end else if (i_q == 2'd3) begin
            state_q <= StCarve;
          end else begin
            i_q     <= i_q + 2'd1;
            state_q <= StNbRd;
          end
        end
        StWallWr: state_q <= StCarve;
        StCarve: begin
          i_q     <= 2'd0;
          state_q <= StQRd;
        end
        StQRd:   state_q <= StQWait;
        StQWait: state_q <= StQCheck;
        StQCheck: begin
          if (map_rd_q[0] == 1'b0 && map_rd_q[2] == 1'b0 &&
              count_q < CountW'(FrontierDepth)) begin
            state_q <= StQWr;
          end else if (i_q == 2'd3) begin
            rsp_q.step_done     <= 1'b1;
            rsp_q.maze_finished <= (count_q == '0);
            state_q             <= StResp;
          end else begin
            i_q     <= i_q + 2'd1;
            state_q <= StQRd;
          end
        end
        StQWr: begin
          count_q <= count_q + CountW'(1);
          if (i_q == 2'd3) begin
            rsp_q.step_done     <= 1'b1;
            rsp_q.maze_finished <= 1'b0;
            state_q             <= StResp;
          end else begin
            i_q     <= i_q + 2'd1;
            state_q <= StQRd;
          end
        end
        StResp: begin
          // The response register is cleared once delivered, ready for the next.
          if (!rsp_stall_i) begin
            rsp_q   <= '0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== tb/rmc_checker.sv =====
// ----------------------------------------------------------------------------
// rmc_checker: response predictor and scoreboard for the random maze carver
// Watches all three channels, carves its own copy of the maze on each
// accepted request and compares every delivered response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmc_checker
  import rmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_stall_i,
  input  rmc_req_t            req_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_stall_i,
  input  rmc_rsp_t            rsp_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  // Direction orders, first direction tried in the leftmost slot.
  localparam int DirOrder [24][4] = '{
    '{0, 1, 2, 3}, '{0, 1, 3, 2}, '{0, 2, 1, 3}, '{0, 2, 3, 1},
    '{0, 3, 2, 1}, '{0, 3, 1, 2}, '{1, 0, 2, 3}, '{1, 0, 3, 2},
    '{1, 2, 3, 0}, '{1, 2, 0, 3}, '{1, 3, 0, 2}, '{1, 3, 2, 0},
    '{2, 0, 1, 3}, '{2, 0, 3, 1}, '{2, 1, 3, 0}, '{2, 1, 0, 3},
    '{2, 3, 1, 0}, '{2, 3, 0, 1}, '{3, 0, 1, 2}, '{3, 0, 2, 1},
    '{3, 1, 2, 0}, '{3, 1, 0, 2}, '{3, 2, 1, 0}, '{3, 2, 0, 1}
  };

  logic [5:0]  rows_q, cols_q;
  bit          is_open   [MapDepth];
  bit          is_carved [MapDepth];
  bit          is_queued [MapDepth];
  logic [11:0] frontier  [FrontierDepth];
  int          frontier_len;
  rmc_rsp_t    expected_rsps [$];

  function automatic void clear_maze();
    for (int i = 0; i < MapDepth; i++) begin
      is_open[i]   = 1'b0;
      is_carved[i] = 1'b0;
      is_queued[i] = 1'b0;
    end
    frontier_len = 0;
  endfunction

  // Cell two steps away in direction d, or the cell itself when that leaves the grid.
  function automatic logic [11:0] neighbour_of(logic [11:0] p, logic [1:0] d);
    int nr, nc;
    nr = int'(p[11:6]) + ((d == 2'd0) ? -2 : (d == 2'd1) ? 2 : 0);
    nc = int'(p[5:0]) + ((d == 2'd2) ? -2 : (d == 2'd3) ? 2 : 0);
    if (nr > 0 && nr < int'(rows_q) && nr < MaxDim &&
        nc > 0 && nc < int'(cols_q) && nc < MaxDim) begin
      return {nr[5:0], nc[5:0]};
    end
    return p;
  endfunction

  function automatic rmc_rsp_t carve_request(rmc_req_t r);
    rmc_rsp_t    o;
    int          pos;
    logic [11:0] cur, nb;
    int          wr, wc;
    o = '0;
    if (r.action == ActStart) begin
      clear_maze();
      is_open[{6'd1, 6'd1}]   = 1'b1;
      is_queued[{6'd1, 6'd1}] = 1'b1;
      frontier[0]  = {6'd1, 6'd1};
      frontier_len = 1;
      return o;
    end
    if (frontier_len == 0) begin
      o.maze_finished = 1'b1;
      return o;
    end
    pos = int'(r.pick_random) % frontier_len;
    cur = frontier[pos];
    for (int i = pos; i < frontier_len - 1; i++) frontier[i] = frontier[i + 1];
    frontier_len--;
    is_queued[cur] = 1'b0;
    is_open[cur]   = 1'b1;
    o.cell_row = cur[11:6];
    o.cell_col = cur[5:0];
    for (int i = 0; i < 4; i++) begin
      nb = neighbour_of(cur, 2'(DirOrder[int'(r.order_random) % 24][i]));
      if (is_carved[nb]) begin
        wr = (int'(nb[11:6]) + int'(cur[11:6])) / 2;
        wc = (int'(nb[5:0]) + int'(cur[5:0])) / 2;
        is_open[{wr[5:0], wc[5:0]}] = 1'b1;
        o.wall_row    = wr[5:0];
        o.wall_col    = wc[5:0];
        o.wall_opened = 1'b1;
        break;
      end
    end
    is_carved[cur] = 1'b1;
    for (int i = 0; i < 4; i++) begin
      nb = neighbour_of(cur, i[1:0]);
      if (!is_open[nb] && !is_queued[nb] && frontier_len < FrontierDepth) begin
        frontier[frontier_len] = nb;
        frontier_len++;
        is_queued[nb] = 1'b1;
      end
    end
    o.step_done     = 1'b1;
    o.maze_finished = (frontier_len == 0);
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rmc_rsp_t want;
    if (!rst_ni) begin
      rows_q = 6'd33;
      cols_q = 6'd41;
      clear_maze();
      expected_rsps.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegGridRows) rows_q = cfg_data_i;
        if (cfg_index_i == RegGridCols) cols_q = cfg_data_i;
      end
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected response", 1, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.cell_row !== want.cell_row)
            report("cell_row", rsp_i.cell_row, want.cell_row);
          if (rsp_i.cell_col !== want.cell_col)
            report("cell_col", rsp_i.cell_col, want.cell_col);
          if (rsp_i.wall_row !== want.wall_row)
            report("wall_row", rsp_i.wall_row, want.wall_row);
          if (rsp_i.wall_col !== want.wall_col)
            report("wall_col", rsp_i.wall_col, want.wall_col);
          if (rsp_i.wall_opened !== want.wall_opened)
            report("wall_opened", rsp_i.wall_opened, want.wall_opened);
          if (rsp_i.step_done !== want.step_done)
            report("step_done", rsp_i.step_done, want.step_done);
          if (rsp_i.maze_finished !== want.maze_finished)
            report("maze_finished", rsp_i.maze_finished, want.maze_finished);
        end
      end
      if (req_valid_i && !req_stall_i)
        expected_rsps.insert(expected_rsps.size(), carve_request(req_i));
    end
    pending_o = expected_rsps.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the random maze carver
// Runs directed corner cases, then many small random mazes under random
// backpressure and grid settings; checking is done by rmc_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import rmc_pkg::*;
();

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                req_valid_i = 1'b0;
  logic                req_stall_o;
  rmc_req_t            req_i = '0;
  logic                rsp_valid_o;
  logic                rsp_stall_i = 1'b0;
  rmc_rsp_t            rsp_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = RegGridRows;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int                  errors;
  int                  pending;

  // When set, neither side idles; used for one long burst of requests.
  bit                  no_idle = 1'b0;
  int                  sent = 0;

  always #2 clk_i = ~clk_i;

  random_maze_carver uut (.*);

  rmc_checker scoreboard (
    .clk_i, .rst_ni,
    .req_valid_i, .req_stall_i(req_stall_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_stall_i, .rsp_i(rsp_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // The response side stalls at random, about six percent of the time, unless no_idle is set.
  always @(posedge clk_i) begin
    rsp_stall_i <= !no_idle && ($urandom_range(0, 99) < 6);
  end

  // Offers one request and returns at the edge that accepts it. The stall is
  // checked at the falling edge so the accepting edge is known in advance.
  task automatic send(logic act, logic [RandW-1:0] pick, logic [RandW-1:0] ord);
    if (!no_idle && $urandom_range(0, 99) < 6) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_valid_i          <= 1'b1;
    req_i.action         <= act;
    req_i.pick_random    <= pick;
    req_i.order_random   <= ord;
    do @(negedge clk_i); while (req_stall_o);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic step_rand();
    send(ActStep, RandW'($urandom_range(0, 32767)), RandW'($urandom_range(0, 32767)));
  endtask

  // Registers change only when the block has delivered every response.
  // One edge passes first so that the last accepted request is counted.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(logic [5:0] r, logic [5:0] c);
    write_reg(RegGridRows, r);
    write_reg(RegGridCols, c);
  endtask

  initial begin
    int rows, cols, steps;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A step before any start finds an empty frontier.
    send(ActStep, 15'h7fff, 15'h7fff);
    // Reset grid: a few steps with extreme random values.
    send(ActStart, 15'h0000, 15'h0000);
    send(ActStep, 15'h0000, 15'h0000);
    send(ActStep, 15'h7fff, 15'h7fff);
    send(ActStep, 15'h0000, 15'd23);
    send(ActStep, 15'h7fff, 15'd24);
    // Smallest grid: one cell, no neighbours, so the maze finishes at once,
    // and a further step again meets the empty frontier.
    set_grid(6'd3, 6'd3);
    send(ActStart, 15'h1234, 15'h4321);
    send(ActStep, 15'h0000, 15'h0000);
    send(ActStep, 15'h0000, 15'h0000);
    // Largest grid, then shrink it while the maze is under way.
    set_grid(6'd63, 6'd63);
    send(ActStart, 15'h0, 15'h0);
    for (int i = 0; i < 4; i++) step_rand();
    set_grid(6'd5, 6'd63);
    for (int i = 0; i < 4; i++) step_rand();
    // Degenerate sizes: zero and one keep every neighbour off the grid; then an even grid.
    set_grid(6'd0, 6'd1);
    send(ActStart, 15'h0, 15'h0);
    step_rand();
    step_rand();
    set_grid(6'd4, 6'd6);
    send(ActStart, 15'h0, 15'h0);
    for (int i = 0; i < 4; i++) step_rand();

    // Random part: mostly whole mazes with random content, mostly on small grids.
    while (sent < 1050) begin
      no_idle = (sent > 400 && sent < 650);
      if ($urandom_range(0, 99) < 85) begin
        rows = 2 * $urandom_range(1, 7) + 1;
        cols = 2 * $urandom_range(1, 7) + 1;
      end else if ($urandom_range(0, 1)) begin
        rows = $urandom_range(0, 63);
        cols = $urandom_range(0, 63);
      end else begin
        rows = 63;
        cols = 63;
      end
      set_grid(rows[5:0], cols[5:0]);
      send(ActStart, RandW'($urandom_range(0, 32767)), RandW'($urandom_range(0, 32767)));
      steps = ((rows > 1 ? rows - 1 : 0) / 2) * ((cols > 1 ? cols - 1 : 0) / 2) + 2;
      if (steps > 70) steps = 70;
      // Some mazes are cut short or restarted midway.
      if ($urandom_range(0, 99) < 10) steps = $urandom_range(1, steps);
      for (int i = 0; i < steps; i++) begin
        if ($urandom_range(0, 99) < 2)
          send(ActStart, RandW'($urandom_range(0, 32767)),
               RandW'($urandom_range(0, 32767)));
        else
          step_rand();
      end
    end
    no_idle = 1'b0;
    req_valid_i <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // This bounds the run with a wide margin over the worst case of every request.
  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rmc_pkg.sv
hw/rtl/random_maze_carver.sv
tb/rmc_checker.sv
tb/tb.sv
